[sv/greedy_first_fit_colouring_assert.svh]
// Assertion macros shared by the colouring block's modules.
// Depends on i_clk and i_rst_n being declared in the module that uses them.
`ifndef GREEDY_FIRST_FIT_COLOURING_ASSERT_SVH
`define GREEDY_FIRST_FIT_COLOURING_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GFFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gffc assertion failed");

// Next-cycle implication, checked outside reset.
`define GFFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gffc assertion failed");

`endif

[sv/gffc_pkg.sv]
// Types and constants of the greedy first-fit colouring block.
// No dependencies.
package gffc_pkg;

    localparam int NUM_VERTICES = 1024;
    localparam int VTX_W        = 10;
    localparam int NUM_COLOURS  = 64;
    localparam int COLOUR_W     = 7;
    localparam int CIDX_W       = 6;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    typedef logic [VTX_W-1:0]    t_vtx;
    typedef logic [COLOUR_W-1:0] t_colour;
    typedef logic [CIDX_W-1:0]   t_cidx;

    // One neighbour item as it travels from the front queue to the back end.
    typedef struct packed {
        t_vtx vertex;
        t_vtx nbr;
        logic marks;   // item names a neighbour whose colour may be forbidden
        logic last;
    } t_item;

    // Decision for one vertex, handed to the tally stage.
    typedef struct packed {
        logic    valid;
        t_vtx    vertex;
        t_colour colour;
    } t_pick;

endpackage

[sv/gffc_front.sv]
// Front end: input handshake and a short item queue ahead of the back end.
// Depends on gffc_pkg.
`include "greedy_first_fit_colouring_assert.svh"

module gffc_front import gffc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_vtx  i_vertex,
    input  t_vtx  i_neighbour,
    input  logic  i_neighbour_valid,
    input  logic  i_last,
    input  logic  i_busy,
    input  logic  i_pop,
    output logic  o_head_valid,
    output t_item o_head
);

    t_item             r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    t_item             n_item;

    assign o_in_stall   = (r_count == QCNT_W'(QDEPTH)) || i_busy;
    assign push         = i_in_valid && !o_in_stall;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_q[r_rd_ptr];

    // classify: an item forbids a colour only when it names a neighbour
    always_comb begin
        n_item.vertex = i_vertex;
        n_item.nbr    = i_neighbour;
        n_item.marks  = i_neighbour_valid;
        n_item.last   = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(push) - QCNT_W'(i_pop);
        end
    end

    `GFFC_ASSERT_NOW(a_pop_nonempty, i_pop, r_count != '0)
    `GFFC_ASSERT_NOW(a_count_bound, 1'b1, r_count <= QCNT_W'(QDEPTH))

endmodule

[sv/gffc_back.sv]
// Back end: colour store with clear sweep, forbidden mask and first-fit choice.
// Depends on gffc_pkg.
`include "greedy_first_fit_colouring_assert.svh"

module gffc_back import gffc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cidx i_max_degree,
    input  logic  i_en,
    input  logic  i_head_valid,
    input  t_item i_head,
    output logic  o_pop,
    output logic  o_busy,
    output t_pick o_pick
);

    t_colour                r_mem [NUM_VERTICES];
    t_colour                r_rd_data;
    logic                   r_clearing;
    t_vtx                   r_clr_idx;
    logic                   r_b_valid;
    t_item                  r_b_item;
    logic [NUM_COLOURS-1:0] r_forbid;
    logic                   r_wr_valid;
    t_vtx                   r_wr_addr;
    t_colour                r_wr_colour;

    t_colour                nc;
    t_colour                nc_m1;
    logic                   mark;
    logic [NUM_COLOURS-1:0] mark_bit;
    logic [NUM_COLOURS-1:0] n_forbid;
    logic [NUM_COLOURS-1:0] pmask;
    logic [NUM_COLOURS-1:0] avail;
    logic [NUM_COLOURS-1:0] lowest;
    t_cidx                  low_idx;
    t_colour                chosen;
    logic                   wr_en;

    assign o_busy = r_clearing;
    assign o_pop  = i_en && i_head_valid && !r_clearing;

    // forward a colour written at the edge that loaded the read data
    assign nc    = (r_wr_valid && r_wr_addr == r_b_item.nbr) ? r_wr_colour : r_rd_data;
    assign nc_m1 = nc - COLOUR_W'(1);
    assign mark  = r_b_item.marks && (nc != '0) && (nc_m1 <= {1'b0, i_max_degree});

    always_comb begin
        mark_bit = '0;
        if (mark) begin
            mark_bit = {{(NUM_COLOURS-1){1'b0}}, 1'b1} << nc_m1[CIDX_W-1:0];
        end
        n_forbid = r_forbid | mark_bit;
        for (int i = 0; i < NUM_COLOURS; i++) begin
            pmask[i] = (CIDX_W'(i) <= i_max_degree);
        end
        avail  = ~n_forbid & pmask;
        lowest = avail & (~avail + {{(NUM_COLOURS-1){1'b0}}, 1'b1});
        low_idx = '0;
        for (int i = 0; i < NUM_COLOURS; i++) begin
            if (lowest[i]) begin
                low_idx = low_idx | CIDX_W'(i);
            end
        end
        chosen = (avail != '0) ? ({1'b0, low_idx} + COLOUR_W'(1)) : '0;
    end

    assign wr_en = i_en && r_b_valid && r_b_item.last;

    assign o_pick.valid  = r_b_valid && r_b_item.last;
    assign o_pick.vertex = r_b_item.vertex;
    assign o_pick.colour = chosen;

    // colour store: clear sweep after reset, then one decision write per run
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= '0;
        end else if (wr_en) begin
            r_mem[r_b_item.vertex] <= chosen;
        end
        if (o_pop) begin
            r_rd_data <= r_mem[i_head.nbr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_item <= i_head;
        end
        if (i_en) begin
            r_wr_addr   <= r_b_item.vertex;
            r_wr_colour <= chosen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_b_valid  <= 1'b0;
            r_forbid   <= '0;
            r_wr_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + VTX_W'(1);
                if (r_clr_idx == VTX_W'(NUM_VERTICES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_en) begin
                r_b_valid  <= o_pop;
                r_wr_valid <= wr_en;
                if (r_b_valid) begin
                    r_forbid <= r_b_item.last ? '0 : n_forbid;
                end
            end
        end
    end

    `GFFC_ASSERT_NOW(a_no_pop_clearing, r_clearing, !o_pop)
    `GFFC_ASSERT_NOW(a_colour_in_palette, wr_en,
                     chosen <= ({1'b0, i_max_degree} + COLOUR_W'(1)))
    `GFFC_ASSERT_NEXT(a_mask_cleared_after_run, wr_en, r_forbid == '0)

endmodule

[sv/gffc_tally.sv]
// Tally and output stage: distinct-colour count and the result register.
// Depends on gffc_pkg.
`include "greedy_first_fit_colouring_assert.svh"

module gffc_tally import gffc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_pick   i_pick,
    output logic    o_en,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_vtx    o_coloured_vertex,
    output t_colour o_colour,
    output logic    o_failed,
    output t_colour o_colour_count
);

    logic [NUM_COLOURS-1:0] r_used;
    t_colour                r_count;
    logic                   r_out_valid;
    t_vtx                   r_vertex;
    t_colour                r_colour;
    t_cidx                  cidx;
    logic                   fresh;
    t_colour                n_count;

    assign o_en    = !r_out_valid || !i_out_stall;
    assign cidx    = CIDX_W'(i_pick.colour - COLOUR_W'(1));
    assign fresh   = (i_pick.colour != '0) && !r_used[cidx];
    assign n_count = r_count + COLOUR_W'(fresh);

    assign o_out_valid       = r_out_valid;
    assign o_coloured_vertex = r_vertex;
    assign o_colour          = r_colour;
    assign o_failed          = (r_colour == '0);
    assign o_colour_count    = r_count;

    always_ff @(posedge i_clk) begin
        if (o_en && i_pick.valid) begin
            r_vertex <= i_pick.vertex;
            r_colour <= i_pick.colour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (o_en) begin
            r_out_valid <= i_pick.valid;
            if (i_pick.valid && fresh) begin
                r_used[cidx] <= 1'b1;
                r_count      <= n_count;
            end
        end
    end

    `GFFC_ASSERT_NOW(a_count_matches_mask, 1'b1, r_count == COLOUR_W'($countones(r_used)))

endmodule

[sv/greedy_first_fit_colouring.sv]
// Greedy first-fit vertex colouring, top level.
// The last item of a run passes the item queue, the back-end register and the result register.
// Throughput: one item per cycle, set by the colour store's single read port, unless stalled.
// Reset (synchronous, active low) starts a sweep that clears all 1024 colour store entries;
// input stall stays high through it. Configuration writes are taken at any edge outside reset.
// Depends on gffc_pkg, gffc_front, gffc_back and gffc_tally.

module greedy_first_fit_colouring import gffc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: palette size is max_degree plus one
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    // item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [9:0]  i_vertex,
    input  logic [9:0]  i_neighbour,
    input  logic        i_neighbour_valid,
    input  logic        i_last,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_coloured_vertex,
    output logic [6:0]  o_colour,
    output logic        o_failed,
    output logic [6:0]  o_colour_count
);

    t_cidx r_max_degree;
    logic  busy;
    logic  pop;
    logic  en;
    logic  head_valid;
    t_item head;
    t_pick pick;

    // hold the configured maximum degree; reset value is the widest palette
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_degree <= CIDX_W'(NUM_COLOURS - 1);
        end else if (i_cfg_we) begin
            r_max_degree <= i_cfg_wdata;
        end
    end

    // front: accept each transfer into a short queue so the back end can stall on its own
    gffc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_vertex          (i_vertex),
        .i_neighbour       (i_neighbour),
        .i_neighbour_valid (i_neighbour_valid),
        .i_last            (i_last),
        .i_busy            (busy),
        .i_pop             (pop),
        .o_head_valid      (head_valid),
        .o_head            (head)
    );

    // back: read the neighbour colour, accumulate the forbidden mask, pick on the last item
    gffc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_degree (r_max_degree),
        .i_en         (en),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_busy       (busy),
        .o_pick       (pick)
    );

    // tally: count distinct colours and hold the result until its transfer
    gffc_tally u_tally (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pick            (pick),
        .o_en              (en),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_coloured_vertex (o_coloured_vertex),
        .o_colour          (o_colour),
        .o_failed          (o_failed),
        .o_colour_count    (o_colour_count)
    );

endmodule
